/* hdl/ibns_pkg.sv */
// shared types, constants and codes of the image scaler
package ibns_pkg;

    localparam int POS_W    = 12;
    localparam int STEP_W   = 25;
    localparam int DIM_W    = 9;
    localparam int DIMC_W   = 13;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = POS_W + STEP_W;
    localparam int IDX_W    = PROD_W - FRAC_W + 1;
    localparam int CH_W     = 8;
    localparam int NUM_CH   = 3;
    localparam int PIX_W    = CH_W * NUM_CH;
    localparam int NUM_BANK = 4;
    localparam int CFG_IDX_W = 3;
    localparam int HSUM_W   = FRAC_W + CH_W;
    localparam int VSUM_W   = 2 * FRAC_W + CH_W + 1;
    localparam int S_TDATA_W = 2 * POS_W + PIX_W;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic INTERP_NEAREST  = 1'b0;
    localparam logic INTERP_BILINEAR = 1'b1;

    localparam logic COLOR_MONO = 1'b0;
    localparam logic COLOR_RGB  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH   = 3'd0,
        CFG_SRC_HEIGHT  = 3'd1,
        CFG_STEP_X      = 3'd2,
        CFG_STEP_Y      = 3'd3,
        CFG_INTERP_MODE = 3'd4,
        CFG_COLOR_MODE  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic              valid;
        logic              is_load;
        logic              wr_ok;
        logic              x0_odd;
        logic              x1_odd;
        logic              y0_odd;
        logic              y1_odd;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
    } ibns_ctrl_t;

endpackage

/* hdl/ibns_ram.sv */
// generic single write port ram with registered read
module ibns_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/ibns_addr.sv */
// source position multiply, neighbour index clamp and fraction split
module ibns_addr #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int XB = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1,
    parameter int YB = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            ce,
    input  logic                            in_valid,
    input  logic                            in_mode,
    input  logic [ibns_pkg::POS_W-1:0]      in_x,
    input  logic [ibns_pkg::POS_W-1:0]      in_y,
    input  logic [ibns_pkg::PIX_W-1:0]      in_pix,
    input  logic [ibns_pkg::DIM_W-1:0]      cfg_src_width,
    input  logic [ibns_pkg::DIM_W-1:0]      cfg_src_height,
    input  logic [ibns_pkg::STEP_W-1:0]     cfg_step_x,
    input  logic [ibns_pkg::STEP_W-1:0]     cfg_step_y,
    input  logic                            cfg_interp,
    output ibns_pkg::ibns_ctrl_t            ctrl,
    output logic [XB-1:0]                   x0,
    output logic [XB-1:0]                   x1,
    output logic [YB-1:0]                   y0,
    output logic [YB-1:0]                   y1,
    output logic [ibns_pkg::PIX_W-1:0]      wr_pix
);

    import ibns_pkg::*;

    localparam logic [PROD_W:0] HALF = (PROD_W+1)'(1) << (FRAC_W - 1);

    function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] v,
                                                   input logic [IDX_W-1:0] last);
        return (v > last) ? last : v;
    endfunction

    function automatic logic [IDX_W-1:0] last_idx(input logic [DIM_W-1:0] dim,
                                                  input int maxv);
        logic [DIMC_W-1:0] d;
        logic [DIMC_W-1:0] e;
        d = DIMC_W'(dim);
        if (d == '0) begin
            e = DIMC_W'(1);
        end else if (d > DIMC_W'(maxv)) begin
            e = DIMC_W'(maxv);
        end else begin
            e = d;
        end
        return IDX_W'(e - DIMC_W'(1));
    endfunction

    // stage one: position products
    logic              v1_reg;
    logic              mode1_reg;
    logic [POS_W-1:0]  dx1_reg, dy1_reg;
    logic [PROD_W-1:0] px1_reg, py1_reg;
    logic [PROD_W-1:0] px1_next, py1_next;
    logic [PIX_W-1:0]  pix1_reg;

    assign px1_next = PROD_W'(in_x) * PROD_W'(cfg_step_x);
    assign py1_next = PROD_W'(in_y) * PROD_W'(cfg_step_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
        end
        if (ce) begin
            mode1_reg <= in_mode;
            dx1_reg   <= in_x;
            dy1_reg   <= in_y;
            px1_reg   <= px1_next;
            py1_reg   <= py1_next;
            pix1_reg  <= in_pix;
        end
    end

    // stage two: neighbour indexes
    logic [PROD_W:0]   rnd_x, rnd_y;
    logic [IDX_W-1:0]  sel_x, sel_y, last_x, last_y;
    logic [IDX_W-1:0]  qx0, qx1, qy0, qy1;
    logic [IDX_W-1:0]  ex0, ex1, ey0, ey1;
    logic              bil;
    logic              is_load;
    ibns_ctrl_t        ctrl_next, ctrl_reg;
    logic [XB-1:0]     x0_reg, x1_reg;
    logic [YB-1:0]     y0_reg, y1_reg;
    logic [PIX_W-1:0]  wr_pix_reg;

    assign bil     = (cfg_interp == INTERP_BILINEAR);
    assign is_load = (mode1_reg == MODE_LOAD);
    assign rnd_x   = {1'b0, px1_reg} + HALF;
    assign rnd_y   = {1'b0, py1_reg} + HALF;
    assign sel_x   = bil ? IDX_W'(px1_reg[PROD_W-1:FRAC_W]) : rnd_x[PROD_W:FRAC_W];
    assign sel_y   = bil ? IDX_W'(py1_reg[PROD_W-1:FRAC_W]) : rnd_y[PROD_W:FRAC_W];
    assign last_x  = last_idx(cfg_src_width, MAX_WIDTH);
    assign last_y  = last_idx(cfg_src_height, MAX_HEIGHT);
    assign qx0     = clamp_idx(sel_x, last_x);
    assign qy0     = clamp_idx(sel_y, last_y);
    assign qx1     = bil ? clamp_idx(sel_x + IDX_W'(1), last_x) : qx0;
    assign qy1     = bil ? clamp_idx(sel_y + IDX_W'(1), last_y) : qy0;
    assign ex0     = is_load ? IDX_W'(dx1_reg) : qx0;
    assign ey0     = is_load ? IDX_W'(dy1_reg) : qy0;
    assign ex1     = is_load ? IDX_W'(dx1_reg) : qx1;
    assign ey1     = is_load ? IDX_W'(dy1_reg) : qy1;

    always_comb begin
        ctrl_next.valid   = v1_reg;
        ctrl_next.is_load = is_load;
        ctrl_next.wr_ok   = (DIMC_W'(dx1_reg) < DIMC_W'(MAX_WIDTH)) &&
                            (DIMC_W'(dy1_reg) < DIMC_W'(MAX_HEIGHT));
        ctrl_next.x0_odd  = ex0[0];
        ctrl_next.x1_odd  = ex1[0];
        ctrl_next.y0_odd  = ey0[0];
        ctrl_next.y1_odd  = ey1[0];
        ctrl_next.fx      = (bil && !is_load) ? px1_reg[FRAC_W-1:0] : '0;
        ctrl_next.fy      = (bil && !is_load) ? py1_reg[FRAC_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (ce) begin
            ctrl_reg <= ctrl_next;
        end
        if (ce) begin
            x0_reg     <= ex0[XB-1:0];
            x1_reg     <= ex1[XB-1:0];
            y0_reg     <= ey0[YB-1:0];
            y1_reg     <= ey1[YB-1:0];
            wr_pix_reg <= pix1_reg;
        end
    end

    assign ctrl   = ctrl_reg;
    assign x0     = x0_reg;
    assign x1     = x1_reg;
    assign y0     = y0_reg;
    assign y1     = y1_reg;
    assign wr_pix = wr_pix_reg;

endmodule

/* hdl/ibns_lane.sv */
// one channel lane: horizontal blend registered, then vertical blend
module ibns_lane (
    input  logic                          aclk,
    input  logic                          ce,
    input  logic [ibns_pkg::CH_W-1:0]     s00,
    input  logic [ibns_pkg::CH_W-1:0]     s10,
    input  logic [ibns_pkg::CH_W-1:0]     s01,
    input  logic [ibns_pkg::CH_W-1:0]     s11,
    input  logic [ibns_pkg::FRAC_W-1:0]   fx,
    input  logic [ibns_pkg::FRAC_W-1:0]   fy,
    output logic [ibns_pkg::CH_W-1:0]     res
);

    import ibns_pkg::*;

    localparam logic [FRAC_W:0] ONE = (FRAC_W+1)'(1) << FRAC_W;

    logic [FRAC_W:0]   wx0, wy0;
    logic [HSUM_W:0]   h0_full, h1_full;
    logic [HSUM_W-1:0] h0_reg, h1_reg;
    logic [FRAC_W-1:0] fy_reg;
    logic [VSUM_W-1:0] v_sum;

    assign wx0     = ONE - {1'b0, fx};
    assign h0_full = (HSUM_W+1)'(wx0) * (HSUM_W+1)'(s00) + (HSUM_W+1)'(fx) * (HSUM_W+1)'(s10);
    assign h1_full = (HSUM_W+1)'(wx0) * (HSUM_W+1)'(s01) + (HSUM_W+1)'(fx) * (HSUM_W+1)'(s11);

    always_ff @(posedge aclk) begin
        if (ce) begin
            h0_reg <= h0_full[HSUM_W-1:0];
            h1_reg <= h1_full[HSUM_W-1:0];
            fy_reg <= fy;
        end
    end

    assign wy0   = ONE - {1'b0, fy_reg};
    assign v_sum = VSUM_W'(wy0) * VSUM_W'(h0_reg) + VSUM_W'(fy_reg) * VSUM_W'(h1_reg);
    assign res   = v_sum[2*FRAC_W +: CH_W];

endmodule

/* hdl/image_resize_bilinear_nearest.sv */
// a query passes the product, index, bank read, blend and output registers on its way to m_tvalid
// throughput: one transaction per cycle while the pipeline is not held, loads and queries freely mixed
// four parity banks (column and row parity) give one read port per neighbour
// the pipeline holds as a whole only while a result waits and m_tready is low
// aresetn (synchronous) empties the pipeline and sets the registers to
// their defaults; the frame store is not cleared
module image_resize_bilinear_nearest #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ibns_pkg::S_TDATA_W-1:0]    s_tdata,  // pos_x, pos_y, in_ch0, in_ch1, in_ch2
    input  logic                              s_tuser,  // mode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ibns_pkg::PIX_W-1:0]        m_tdata,  // out_ch0, out_ch1, out_ch2
    input  logic                              cfg_wr_en,
    input  logic [ibns_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [ibns_pkg::STEP_W-1:0]       cfg_wdata
);

    import ibns_pkg::*;

    localparam int XB    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int YB    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XH    = (XB > 1) ? XB - 1 : 1;
    localparam int YH    = (YB > 1) ? YB - 1 : 1;
    localparam int BANK_DEPTH = 1 << (XH + YH);

    // configuration registers
    logic [DIM_W-1:0]  src_width_reg, src_height_reg;
    logic [STEP_W-1:0] step_x_reg, step_y_reg;
    logic              interp_reg, color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= DIM_W'(256);
            src_height_reg <= DIM_W'(256);
            step_x_reg     <= STEP_W'(65536);
            step_y_reg     <= STEP_W'(65536);
            interp_reg     <= INTERP_BILINEAR;
            color_reg      <= COLOR_RGB;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SRC_WIDTH:   src_width_reg  <= cfg_wdata[DIM_W-1:0];
                CFG_SRC_HEIGHT:  src_height_reg <= cfg_wdata[DIM_W-1:0];
                CFG_STEP_X:      step_x_reg     <= cfg_wdata;
                CFG_STEP_Y:      step_y_reg     <= cfg_wdata;
                CFG_INTERP_MODE: interp_reg     <= cfg_wdata[0];
                CFG_COLOR_MODE:  color_reg      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // pipeline advance
    logic ce;
    logic m_tvalid_reg;

    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;

    // index generation
    ibns_ctrl_t      ctrl2;
    logic [XB-1:0]   x0, x1;
    logic [YB-1:0]   y0, y1;
    logic [PIX_W-1:0] wr_pix;

    ibns_addr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .XB         (XB),
        .YB         (YB)
    ) u_addr (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ce             (ce),
        .in_valid       (s_tvalid),
        .in_mode        (s_tuser),
        .in_x           (s_tdata[POS_W-1:0]),
        .in_y           (s_tdata[2*POS_W-1:POS_W]),
        .in_pix         (s_tdata[S_TDATA_W-1:2*POS_W]),
        .cfg_src_width  (src_width_reg),
        .cfg_src_height (src_height_reg),
        .cfg_step_x     (step_x_reg),
        .cfg_step_y     (step_y_reg),
        .cfg_interp     (interp_reg),
        .ctrl           (ctrl2),
        .x0             (x0),
        .x1             (x1),
        .y0             (y0),
        .y1             (y1),
        .wr_pix         (wr_pix)
    );

    // parity banked frame store
    logic [XB:0]     x0e, x1e;
    logic [YB:0]     y0e, y1e;
    logic [XH-1:0]   x0h, x1h;
    logic [YH-1:0]   y0h, y1h;
    logic [NUM_BANK-1:0] bank_we;
    logic [PIX_W-1:0] bank_rd [NUM_BANK];

    assign x0e = {1'b0, x0};
    assign x1e = {1'b0, x1};
    assign y0e = {1'b0, y0};
    assign y1e = {1'b0, y1};
    assign x0h = x0e[XH:1];
    assign x1h = x1e[XH:1];
    assign y0h = y0e[YH:1];
    assign y1h = y1e[YH:1];

    for (genvar b = 0; b < NUM_BANK; b++) begin : g_bank
        localparam logic XP = 1'((b >> 0) & 1);
        localparam logic YP = 1'((b >> 1) & 1);
        logic [XH-1:0] col;
        logic [YH-1:0] row;

        assign col = (ctrl2.x0_odd == XP) ? x0h : x1h;
        assign row = (ctrl2.y0_odd == YP) ? y0h : y1h;
        assign bank_we[b] = ce && ctrl2.valid && ctrl2.is_load && ctrl2.wr_ok &&
                            (ctrl2.x0_odd == XP) && (ctrl2.y0_odd == YP);

        ibns_ram #(
            .WIDTH (PIX_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .aclk    (aclk),
            .wr_en   (bank_we[b]),
            .wr_addr ({y0h, x0h}),
            .wr_data (wr_pix),
            .rd_en   (ce),
            .rd_addr ({row, col}),
            .rd_data (bank_rd[b])
        );
    end

    // read stage control
    ibns_ctrl_t ctrl3_reg, ctrl3_next;

    always_comb begin
        ctrl3_next       = ctrl2;
        ctrl3_next.valid = ctrl2.valid && !ctrl2.is_load;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl3_reg <= '0;
        end else if (ce) begin
            ctrl3_reg <= ctrl3_next;
        end
    end

    logic [1:0] sel00, sel10, sel01, sel11;

    assign sel00 = {ctrl3_reg.y0_odd, ctrl3_reg.x0_odd};
    assign sel10 = {ctrl3_reg.y0_odd, ctrl3_reg.x1_odd};
    assign sel01 = {ctrl3_reg.y1_odd, ctrl3_reg.x0_odd};
    assign sel11 = {ctrl3_reg.y1_odd, ctrl3_reg.x1_odd};

    // channel lanes
    logic [CH_W-1:0] lane_res [NUM_CH];

    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        ibns_lane u_lane (
            .aclk (aclk),
            .ce   (ce),
            .s00  (bank_rd[sel00][c*CH_W +: CH_W]),
            .s10  (bank_rd[sel10][c*CH_W +: CH_W]),
            .s01  (bank_rd[sel01][c*CH_W +: CH_W]),
            .s11  (bank_rd[sel11][c*CH_W +: CH_W]),
            .fx   (ctrl3_reg.fx),
            .fy   (ctrl3_reg.fy),
            .res  (lane_res[c])
        );
    end

    logic v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (ce) begin
            v4_reg <= ctrl3_reg.valid;
        end
    end

    // merge of lane results into the output register
    logic [PIX_W-1:0] m_tdata_reg, m_tdata_next;
    logic             gray;

    assign gray = (color_reg == COLOR_MONO);

    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[CH_W-1:0] = lane_res[0];
        if (!gray) begin
            m_tdata_next[2*CH_W-1:CH_W]   = lane_res[1];
            m_tdata_next[3*CH_W-1:2*CH_W] = lane_res[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= v4_reg;
        end
        if (ce) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_one_bank_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(bank_we))
        else $error("more than one frame store bank written");

    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("pipeline stalled without a pending result");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !ctrl3_reg.valid && !v4_reg)
        else $error("pipeline valid survived reset");

    a_nearest_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl2.valid && !ctrl2.is_load && interp_reg == INTERP_NEAREST) |->
        (x0 == x1 && y0 == y1 && ctrl2.fx == '0 && ctrl2.fy == '0))
        else $error("nearest query with distinct neighbours or nonzero fraction");

    a_neighbour_parity: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl2.valid && !ctrl2.is_load) |->
        ((x0 == x1 || ctrl2.x0_odd != ctrl2.x1_odd) &&
         (y0 == y1 || ctrl2.y0_odd != ctrl2.y1_odd)))
        else $error("neighbours fall into the same bank");
`endif

endmodule
